>>> hw/rtl/tmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg
// Types, constants and helpers of the transform matrix composer.
// ----------------------------------------------------------------------------
package tmc_pkg;

	localparam int ELEMENT_WIDTH = 32;
	localparam int FRACTION_BITS = 16;
	localparam int WIDE_W        = 2 * ELEMENT_WIDTH + 2;
	localparam int ACC_W         = 2 * ELEMENT_WIDTH - FRACTION_BITS + 2;
	localparam int CORDIC_STEPS  = 24;
	localparam int CORDIC_FRAC   = 30;
	localparam int CW            = 34;
	localparam int RW            = 34;
	localparam int ZMW           = 26;

	localparam logic [2:0] OP_IDENTITY  = 3'd0;
	localparam logic [2:0] OP_ROTATE_X  = 3'd1;
	localparam logic [2:0] OP_ROTATE_Y  = 3'd2;
	localparam logic [2:0] OP_ROTATE_Z  = 3'd3;
	localparam logic [2:0] OP_TRANSLATE = 3'd4;
	localparam logic [2:0] OP_SCALE     = 3'd5;
	localparam logic [2:0] OP_READ_OUT  = 3'd6;

	localparam logic signed [CW-1:0]  CORDIC_GAIN_INV = CW'(652032874);
	localparam logic signed [ZMW-1:0] DEG_TO_RAD_Q30  = ZMW'(18740330);
	localparam logic signed [RW-1:0]  DEG_360 = RW'(360) <<< FRACTION_BITS;
	localparam logic signed [RW-1:0]  DEG_180 = RW'(180) <<< FRACTION_BITS;
	localparam logic signed [RW-1:0]  DEG_90  = RW'(90) <<< FRACTION_BITS;

	typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] angle_degrees;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic signed [31:0] z_value;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic               last_element;
	} elem_word_t;

	function automatic elem_t sat_elem(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = $signed({{(WIDE_W-ELEMENT_WIDTH+1){1'b0}}, {(ELEMENT_WIDTH-1){1'b1}}});
		lo = -hi - 1;
		if (v > hi) begin
			return hi[ELEMENT_WIDTH-1:0];
		end else if (v < lo) begin
			return lo[ELEMENT_WIDTH-1:0];
		end
		return v[ELEMENT_WIDTH-1:0];
	endfunction

	function automatic elem_t one_q();
		return sat_elem(WIDE_W'(signed'(1)) <<< FRACTION_BITS);
	endfunction

	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:    return CW'(32'h3243F6A8);
			5'd1:    return CW'(32'h1DAC6705);
			5'd2:    return CW'(32'h0FADBAFC);
			5'd3:    return CW'(32'h07F56EA6);
			5'd4:    return CW'(32'h03FEAB76);
			5'd5:    return CW'(32'h01FFD55B);
			5'd6:    return CW'(32'h00FFFAAA);
			5'd7:    return CW'(32'h007FFF55);
			5'd8:    return CW'(32'h003FFFEA);
			5'd9:    return CW'(32'h001FFFFD);
			5'd10:   return CW'(32'h000FFFFF);
			5'd11:   return CW'(32'h0007FFFF);
			5'd12:   return CW'(32'h0003FFFF);
			5'd13:   return CW'(32'h0001FFFF);
			5'd14:   return CW'(32'h0000FFFF);
			5'd15:   return CW'(32'h00007FFF);
			5'd16:   return CW'(32'h00003FFF);
			5'd17:   return CW'(32'h00001FFF);
			5'd18:   return CW'(32'h00000FFF);
			5'd19:   return CW'(32'h000007FF);
			5'd20:   return CW'(32'h000003FF);
			5'd21:   return CW'(32'h000001FF);
			5'd22:   return CW'(32'h000000FF);
			5'd23:   return CW'(32'h0000007F);
			default: return '0;
		endcase
	endfunction

endpackage

>>> hw/rtl/tmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/transform_matrix_composer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transform_matrix_composer
// 4x4 column-major Q16.16 transform matrix with rotate, translate, scale,
// identity and read out commands.
//
//   channel  dir  handshake             payload
//   cmd      in   cmd_valid/cmd_stall   tmc_pkg::cmd_word_t
//   elem     out  elem_valid/elem_stall tmc_pkg::elem_word_t
//
// Identity and unused codes are handled in S_IDLE. Translate/scale run one
// shared multiplier through 64 multiply-adds over the matrix RAM.
// Rotations add 8 reduction steps, the S_FOLD, S_ZMUL and S_ZSH setup
// states, 24 CORDIC steps and the S_TRIG scaling state.
// Read out: S_OUT then S_OUTW per word; S_OUTW waits while elem is stalled.
// Reset marks every entry invalid; invalid entries read as identity.
// ----------------------------------------------------------------------------
module transform_matrix_composer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  tmc_pkg::cmd_word_t   cmd,
	output logic                 elem_valid,
	input  logic                 elem_stall,
	output tmc_pkg::elem_word_t  elem
);

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_FOLD, S_ZMUL, S_ZSH, S_COR, S_TRIG,
		S_RD, S_RDW, S_MUL, S_ACC, S_WR, S_OUT, S_OUTW
	} state_t;

	state_t                                state_q;
	tmc_pkg::cmd_word_t                    cmd_q;
	logic [4:0]                            cnt_q;
	logic [1:0]                            row_q, col_q, k_q;
	logic [3:0]                            oidx_q;
	logic [3:0]                            raddr_q;
	logic [15:0]                           valid_q;
	tmc_pkg::elem_t                        m_q [4];
	logic signed [2*tmc_pkg::ELEMENT_WIDTH-1:0] prod_q;
	logic signed [tmc_pkg::ACC_W-1:0]      acc_q;
	logic                                  mneg_q, negc_q;
	logic [tmc_pkg::RW-1:0]                rem_q;
	logic signed [tmc_pkg::RW-1:0]         r_q;
	logic signed [2*tmc_pkg::ZMW-1:0]      zprod_q;
	logic signed [tmc_pkg::CW-1:0]         x_q, y_q, z_q;
	tmc_pkg::elem_t                        c_q, s_q;
	logic                                  out_valid_q;
	tmc_pkg::elem_word_t                   out_q;

	logic                                  ram_we, ram_re;
	logic [3:0]                            ram_waddr, ram_raddr;
	logic [tmc_pkg::ELEMENT_WIDTH-1:0]     ram_wdata, ram_rdata;
	tmc_pkg::elem_t                        rd_eff;
	tmc_pkg::elem_t                        acc_sat;
	logic                                  out_free;
	logic [tmc_pkg::RW-1:0]                step_sub;
	logic signed [tmc_pkg::RW-1:0]         rf;
	logic                                  rf_neg;
	logic signed [tmc_pkg::CW-1:0]         xs, ys;

	tmc_ram #(.WIDTH(tmc_pkg::ELEMENT_WIDTH), .DEPTH(16)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	function automatic tmc_pkg::elem_t comp_sat(input logic signed [31:0] v);
		return tmc_pkg::sat_elem(tmc_pkg::WIDE_W'(v));
	endfunction

	function automatic tmc_pkg::elem_t r_elem(input logic [2:0] op, input logic [3:0] idx,
			input tmc_pkg::elem_t c, input tmc_pkg::elem_t s,
			input tmc_pkg::cmd_word_t w);
		tmc_pkg::elem_t one;
		tmc_pkg::elem_t ns;
		one = tmc_pkg::one_q();
		ns  = tmc_pkg::sat_elem(-tmc_pkg::WIDE_W'(s));
		case (op)
			tmc_pkg::OP_ROTATE_X: begin
				case (idx)
					4'd0, 4'd15: return one;
					4'd5, 4'd10: return c;
					4'd6:        return ns;
					4'd9:        return s;
					default:     return '0;
				endcase
			end
			tmc_pkg::OP_ROTATE_Y: begin
				case (idx)
					4'd5, 4'd15: return one;
					4'd0, 4'd10: return c;
					4'd2:        return s;
					4'd8:        return ns;
					default:     return '0;
				endcase
			end
			tmc_pkg::OP_ROTATE_Z: begin
				case (idx)
					4'd10, 4'd15: return one;
					4'd0, 4'd5:   return c;
					4'd1:         return s;
					4'd4:         return ns;
					default:      return '0;
				endcase
			end
			tmc_pkg::OP_TRANSLATE: begin
				case (idx)
					4'd0, 4'd5, 4'd10, 4'd15: return one;
					4'd12:   return comp_sat(w.x_value);
					4'd13:   return comp_sat(w.y_value);
					4'd14:   return comp_sat(w.z_value);
					default: return '0;
				endcase
			end
			tmc_pkg::OP_SCALE: begin
				case (idx)
					4'd0:    return comp_sat(w.x_value);
					4'd5:    return comp_sat(w.y_value);
					4'd10:   return comp_sat(w.z_value);
					4'd15:   return one;
					default: return '0;
				endcase
			end
			default: return '0;
		endcase
	endfunction

	assign cmd_stall  = (state_q != S_IDLE);
	assign elem_valid = out_valid_q;
	assign elem       = out_q;
	assign out_free   = !out_valid_q || !elem_stall;

	assign rd_eff = valid_q[raddr_q] ? tmc_pkg::elem_t'(ram_rdata)
		: ((raddr_q[3:2] == raddr_q[1:0]) ? tmc_pkg::one_q() : '0);
	assign acc_sat = tmc_pkg::sat_elem(tmc_pkg::WIDE_W'(acc_q));

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = {k_q, row_q};
		ram_we    = 1'b0;
		ram_waddr = {col_q, row_q};
		ram_wdata = acc_sat;
		case (state_q)
			S_RD:    ram_re = 1'b1;
			S_OUT: begin
				ram_re    = 1'b1;
				ram_raddr = oidx_q;
			end
			S_WR:    ram_we = 1'b1;
			default: ;
		endcase
	end

	assign step_sub = tmc_pkg::DEG_360 << cnt_q[2:0];
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;

	always_comb begin
		rf     = mneg_q ? -$signed(rem_q) : $signed(rem_q);
		rf_neg = 1'b0;
		if (rf < 0) begin
			rf = rf + tmc_pkg::DEG_360;
		end
		if (rf >= tmc_pkg::DEG_180) begin
			rf = rf - tmc_pkg::DEG_360;
		end
		if (rf > tmc_pkg::DEG_90) begin
			rf     = tmc_pkg::DEG_180 - rf;
			rf_neg = 1'b1;
		end else if (rf < -tmc_pkg::DEG_90) begin
			rf     = -tmc_pkg::DEG_180 - rf;
			rf_neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			oidx_q      <= '0;
		end else begin
			if (out_valid_q && !elem_stall && state_q != S_OUTW) begin
				out_valid_q <= 1'b0;
			end
			if (ram_re) begin
				raddr_q <= ram_raddr;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						row_q  <= '0;
						col_q  <= '0;
						k_q    <= '0;
						oidx_q <= '0;
						acc_q  <= '0;
						case (cmd.operation)
							tmc_pkg::OP_IDENTITY: valid_q <= '0;
							tmc_pkg::OP_ROTATE_X, tmc_pkg::OP_ROTATE_Y,
							tmc_pkg::OP_ROTATE_Z: begin
								mneg_q  <= cmd.angle_degrees[31];
								rem_q   <= cmd.angle_degrees[31]
									? -tmc_pkg::RW'(cmd.angle_degrees)
									: tmc_pkg::RW'(cmd.angle_degrees);
								cnt_q   <= 5'd7;
								state_q <= S_RED;
							end
							tmc_pkg::OP_TRANSLATE, tmc_pkg::OP_SCALE: state_q <= S_RD;
							tmc_pkg::OP_READ_OUT: state_q <= S_OUT;
							default: ;
						endcase
					end
				end
				S_RED: begin
					if (rem_q >= step_sub) begin
						rem_q <= rem_q - step_sub;
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					r_q     <= rf;
					negc_q  <= rf_neg;
					state_q <= S_ZMUL;
				end
				S_ZMUL: begin
					zprod_q <= $signed(r_q[tmc_pkg::ZMW-1:0]) * tmc_pkg::DEG_TO_RAD_Q30;
					state_q <= S_ZSH;
				end
				S_ZSH: begin
					z_q     <= tmc_pkg::CW'(zprod_q >>> tmc_pkg::FRACTION_BITS);
					x_q     <= tmc_pkg::CORDIC_GAIN_INV;
					y_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				S_COR: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - tmc_pkg::atan_q30(cnt_q);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + tmc_pkg::atan_q30(cnt_q);
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(tmc_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_TRIG;
					end
				end
				S_TRIG: begin
					c_q <= tmc_pkg::sat_elem(tmc_pkg::WIDE_W'((negc_q ? -x_q : x_q)
						>>> (tmc_pkg::CORDIC_FRAC - tmc_pkg::FRACTION_BITS)));
					s_q <= tmc_pkg::sat_elem(tmc_pkg::WIDE_W'(y_q
						>>> (tmc_pkg::CORDIC_FRAC - tmc_pkg::FRACTION_BITS)));
					state_q <= S_RD;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					m_q[k_q] <= rd_eff;
					k_q      <= k_q + 2'd1;
					state_q  <= (k_q == 2'd3) ? S_MUL : S_RD;
				end
				S_MUL: begin
					prod_q  <= m_q[k_q] * r_elem(cmd_q.operation, {col_q, k_q},
						c_q, s_q, cmd_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_q + tmc_pkg::ACC_W'(prod_q >>> tmc_pkg::FRACTION_BITS);
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_WR : S_MUL;
				end
				S_WR: begin
					valid_q[{col_q, row_q}] <= 1'b1;
					acc_q <= '0;
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						row_q   <= row_q + 2'd1;
						state_q <= (row_q == 2'd3) ? S_IDLE : S_RD;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_OUT: state_q <= S_OUTW;
				S_OUTW: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.element_index <= oidx_q;
						out_q.element_value <= 32'(rd_eff);
						out_q.last_element  <= (oidx_q == 4'd15);
						oidx_q              <= oidx_q + 4'd1;
						state_q             <= (oidx_q == 4'd15) ? S_IDLE : S_OUT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem.last_element |-> elem.element_index == 4'd15)
		else $error("last word not at index 15");

	a_cordic_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COR |-> cnt_q < 5'(tmc_pkg::CORDIC_STEPS))
		else $error("cordic step count overrun");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> cmd_stall && !ram_re)
		else $error("matrix write while idle or reading");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for transform_matrix_composer. It sends directed and
// random commands, keeps its own Q16.16 copy of the matrix and checks every
// word that comes back from a read out.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam longint ONE_Q = 64'sd65536;
	localparam int CYCLE_LIMIT = 1500000;

	class matrix_scoreboard;
		longint mat[16];
		tmc_pkg::elem_word_t expected[$];
		int errors;
		int words_checked;
		int commands;

		function new();
			errors = 0;
			words_checked = 0;
			commands = 0;
			identity(mat);
		endfunction

		function longint clamp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void identity(ref longint m[16]);
			for (int i = 0; i < 16; i++) m[i] = 0;
			m[0] = ONE_Q; m[5] = ONE_Q; m[10] = ONE_Q; m[15] = ONE_Q;
		endfunction

		function longint arctan_q30(int i);
			longint t[24] = '{
				64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
				64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
				64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
				64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
				64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
				64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
			return t[i];
		endfunction

		function void sine_cosine(longint ang, output longint s, output longint c);
			longint turn, half, quarter, r, x, y, z, nx;
			bit flip;
			turn = 360 * ONE_Q;
			half = 180 * ONE_Q;
			quarter = 90 * ONE_Q;
			flip = 0;
			r = ang % turn;
			if (r < 0) r += turn;
			if (r >= half) r -= turn;
			if (r > quarter) begin
				r = half - r;
				flip = 1;
			end else if (r < -quarter) begin
				r = -half - r;
				flip = 1;
			end
			z = (r * 64'sd18740330) >>> 16;
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= arctan_q30(i);
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += arctan_q30(i);
				end
				x = nx;
			end
			if (flip) x = -x;
			c = clamp(x >>> 14);
			s = clamp(y >>> 14);
		endfunction

		function void note_command(tmc_pkg::cmd_word_t w);
			longint r[16];
			longint res[16];
			longint s, c, acc;
			tmc_pkg::elem_word_t e;
			commands++;
			for (int i = 0; i < 16; i++) r[i] = 0;
			case (w.operation)
				tmc_pkg::OP_IDENTITY: begin
					identity(mat);
					return;
				end
				tmc_pkg::OP_READ_OUT: begin
					for (int i = 0; i < 16; i++) begin
						e.element_index = 4'(i);
						e.element_value = 32'(mat[i]);
						e.last_element = (i == 15);
						expected.push_back(e);
					end
					return;
				end
				OP_UNUSED: return;
				tmc_pkg::OP_ROTATE_X, tmc_pkg::OP_ROTATE_Y, tmc_pkg::OP_ROTATE_Z: begin
					sine_cosine(longint'(w.angle_degrees), s, c);
					r[15] = ONE_Q;
					if (w.operation == tmc_pkg::OP_ROTATE_X) begin
						r[0] = ONE_Q; r[5] = c; r[6] = clamp(-s); r[9] = s; r[10] = c;
					end else if (w.operation == tmc_pkg::OP_ROTATE_Y) begin
						r[5] = ONE_Q; r[0] = c; r[2] = s; r[8] = clamp(-s); r[10] = c;
					end else begin
						r[10] = ONE_Q; r[0] = c; r[1] = s; r[4] = clamp(-s); r[5] = c;
					end
				end
				tmc_pkg::OP_TRANSLATE: begin
					identity(r);
					r[12] = longint'(w.x_value);
					r[13] = longint'(w.y_value);
					r[14] = longint'(w.z_value);
				end
				default: begin
					r[0] = longint'(w.x_value);
					r[5] = longint'(w.y_value);
					r[10] = longint'(w.z_value);
					r[15] = ONE_Q;
				end
			endcase
			for (int col = 0; col < 4; col++) begin
				for (int row = 0; row < 4; row++) begin
					acc = 0;
					for (int k = 0; k < 4; k++)
						acc += (mat[k * 4 + row] * r[col * 4 + k]) >>> 16;
					res[col * 4 + row] = clamp(acc);
				end
			end
			mat = res;
		endfunction

		function void check_word(tmc_pkg::elem_word_t got);
			tmc_pkg::elem_word_t want;
			if (expected.size() == 0) begin
				$error("unexpected word index %0d value %0h", got.element_index,
					got.element_value);
				errors++;
				return;
			end
			want = expected.pop_front();
			words_checked++;
			if (got.element_index !== want.element_index) begin
				$error("element_index expected %0d got %0d", want.element_index,
					got.element_index);
				errors++;
			end
			if (got.element_value !== want.element_value) begin
				$error("element_value [%0d] expected %0h got %0h", want.element_index,
					want.element_value, got.element_value);
				errors++;
			end
			if (got.last_element !== want.last_element) begin
				$error("last_element [%0d] expected %0b got %0b", want.element_index,
					want.last_element, got.last_element);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	tmc_pkg::cmd_word_t cmd;
	logic elem_valid;
	logic elem_stall;
	tmc_pkg::elem_word_t elem;

	matrix_scoreboard sb = new();
	int cycles = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_run = 0;
	bit quiet = 0;

	transform_matrix_composer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.elem(elem)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) sb.note_command(cmd);
		if (arst_n && elem_valid && !elem_stall) sb.check_word(elem);
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (cycles % 500 == 0) quiet = ($urandom_range(0, 3) == 0);
		if (hold_req) begin
			hold_req = 0;
			hold_left = 700;
		end
		if (hold_left > 0) begin
			hold_left--;
			elem_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			elem_stall <= 1'b1;
		end else if (quiet) begin
			elem_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: begin
					stall_run = $urandom_range(0, 2);
					elem_stall <= 1'b1;
				end
				5: begin
					stall_run = $urandom_range(10, 30);
					elem_stall <= 1'b1;
				end
				default: elem_stall <= 1'b0;
			endcase
		end
	end

	function automatic tmc_pkg::cmd_word_t make_cmd(logic [2:0] op, logic [31:0] a,
		logic [31:0] x, logic [31:0] y, logic [31:0] z);
		tmc_pkg::cmd_word_t w;
		w.operation = op;
		w.angle_degrees = a;
		w.x_value = x;
		w.y_value = y;
		w.z_value = z;
		return w;
	endfunction

	task automatic send(tmc_pkg::cmd_word_t w, bit no_gap = 0);
		int gap;
		gap = 0;
		if (!no_gap) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
				5: gap = $urandom_range(10, 40);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			cmd <= tmc_pkg::cmd_word_t'($bits(tmc_pkg::cmd_word_t)'(
				{$urandom, $urandom, $urandom, $urandom, $urandom}));
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(ONE_Q) + $urandom_range(0, 32768) - 16384;
			default: return $urandom_range(0, 262144) - 131072;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 720 * 65536) - 360 * 65536;
	endfunction

	tmc_pkg::cmd_word_t directed[$];
	int reads;

	initial begin
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_X, 30 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Y, -45 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Z, 90 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_X, 180 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Z, 270 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Y, 32'h7FFFFFFF, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_X, 32'h80000000, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Z, -90 * 65536, 0, 0, 0),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_TRANSLATE, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_SCALE, 0, 32'h7FFFFFFF, 32'h80000000, 0),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_IDENTITY, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_SCALE, 0, 2 * 65536, 32768, -65536),
			make_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0),
			make_cmd(tmc_pkg::OP_ROTATE_Y, 1000 * 65536 + 123, 0, 0, 0),
			make_cmd(tmc_pkg::OP_TRANSLATE, 0, 65536, -3 * 65536, 12345),
			make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0)
		};
		foreach (directed[i]) send(directed[i]);

		reads = 0;
		for (int n = 0; n < 300; n++) begin
			logic [2:0] op;
			if (n == 120) begin
				hold_req = 1;
				repeat (6) send(make_cmd(tmc_pkg::OP_READ_OUT, $urandom, 0, 0, 0), 1);
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3: op = tmc_pkg::OP_READ_OUT;
				4: op = tmc_pkg::OP_IDENTITY;
				5, 6, 7, 8: op = tmc_pkg::OP_ROTATE_X + 3'($urandom_range(0, 2));
				9, 10, 11: op = tmc_pkg::OP_ROTATE_X + 3'($urandom_range(0, 2));
				12, 13, 14: op = tmc_pkg::OP_TRANSLATE;
				15, 16, 17: op = tmc_pkg::OP_SCALE;
				18: op = OP_UNUSED;
				default: op = 3'($urandom_range(0, 7));
			endcase
			if (op == tmc_pkg::OP_READ_OUT) reads++;
			send(make_cmd(op, rand_angle(), rand_value(), rand_value(), rand_value()));
		end
		send(make_cmd(tmc_pkg::OP_READ_OUT, 0, 0, 0, 0));
		cmd_valid <= 1'b0;

		while (sb.expected.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Ran %0d commands, %0d random reads, with one long output hold.",
			sb.commands, reads);
		$display("Checked %0d matrix words, %0d mismatches.", sb.words_checked,
			sb.errors);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
